FILE: rtl/core/ipv4_header_encapsulator_assert.svh
// Assertion macros used by the encapsulator's byte sequencer.
`ifndef IPV4_HEADER_ENCAPSULATOR_ASSERT_SVH
`define IPV4_HEADER_ENCAPSULATOR_ASSERT_SVH

// Checked on every rising clock edge, also while reset is asserted.
`define IPV4E_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked on every rising clock edge outside reset.
`define IPV4E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

FILE: rtl/core/ipv4e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4e_pkg;

  // Fixed header field values.
  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [7:0]  TTL_DEFAULT = 8'd64;
  localparam logic [15:0] FLAGS_DF    = 16'h4000;
  localparam logic [15:0] HDR_LEN     = 16'd20;
  localparam logic [15:0] MAX_PAYLOAD = 16'd65515;

  // Header byte counter: 0 to 19 are header bytes, 20 is the first payload byte.
  localparam int unsigned CNT_W       = 5;
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(20);

  // Checksum accumulator holds the sum of ten 16-bit words.
  localparam int unsigned SUM_W = 20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] CFG_GATEWAY_MAC = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_LOCAL   = 2'd2
  } status_e;

  // One accepted input item.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] payload_length;
    logic [7:0]  protocol_number;
    logic [31:0] dest_address;
  } in_item_t;

  // Input item after length and subnet checks, with the raw header sum.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             first_byte;
    logic             last_byte;
    status_e          status;
    logic [15:0]      total_length;
    logic [7:0]       protocol_number;
    logic [31:0]      dest_address;
    logic [SUM_W-1:0] raw_sum;
  } cls_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        is_header;
    logic [47:0] next_hop_mac;
    status_e     status;
  } res_t;

  // Fold the raw sum twice with end-around carry and complement it.
  function automatic logic [15:0] checksum(logic [SUM_W-1:0] raw);
    logic [16:0] fold1;
    logic [15:0] fold2;
    fold1 = 17'(raw[15:0]) + 17'(raw[SUM_W-1:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    return ~fold2;
  endfunction

  // Header byte at position idx, in network order.
  function automatic logic [7:0] hdr_byte(logic [CNT_W-1:0] idx, logic [15:0] total_length,
                                          logic [7:0] protocol, logic [31:0] src,
                                          logic [31:0] dst, logic [15:0] csum);
    logic [15:0] word;
    word = 16'h0000;
    unique case (idx[CNT_W-1:1])
      4'd0:    word = {VER_IHL, 8'h00};
      4'd1:    word = total_length;
      4'd2:    word = 16'h0000;
      4'd3:    word = FLAGS_DF;
      4'd4:    word = {TTL_DEFAULT, protocol};
      4'd5:    word = csum;
      4'd6:    word = src[31:16];
      4'd7:    word = src[15:0];
      4'd8:    word = dst[31:16];
      4'd9:    word = dst[15:0];
      default: word = 16'h0000;
    endcase
    return idx[0] ? word[7:0] : word[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ipv4e_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4e_in_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_valid_i,
  output logic                 s_ready_o,
  input  ipv4e_pkg::in_item_t  s_item_i,
  input  wire  [31:0]          own_address_i,
  input  wire  [31:0]          subnet_mask_i,
  input  wire                  take_i,
  output logic                 valid_o,
  output ipv4e_pkg::cls_item_t item_o
);

  logic                valid_q;
  ipv4e_pkg::in_item_t item_q;
  logic                bad_len;
  logic                local_dst;
  logic [15:0]         total_len;

  // The register frees up whenever the sequencer takes its item.
  assign s_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

  // Length and subnet checks; a bad length takes priority.
  assign bad_len   = (item_q.payload_length == 16'd0) ||
                     (item_q.payload_length > ipv4e_pkg::MAX_PAYLOAD);
  assign local_dst = ((item_q.dest_address & subnet_mask_i) ==
                      (own_address_i & subnet_mask_i));
  assign total_len = item_q.payload_length + ipv4e_pkg::HDR_LEN;

  always_comb begin
    item_o.payload_byte    = item_q.payload_byte;
    item_o.first_byte      = item_q.first_byte;
    item_o.last_byte       = item_q.last_byte;
    item_o.total_length    = total_len;
    item_o.protocol_number = item_q.protocol_number;
    item_o.dest_address    = item_q.dest_address;
    if (bad_len) begin
      item_o.status = ipv4e_pkg::ST_BAD_LEN;
    end else if (local_dst) begin
      item_o.status = ipv4e_pkg::ST_LOCAL;
    end else begin
      item_o.status = ipv4e_pkg::ST_OK;
    end
    // Raw sum of the header words; the checksum word counts as zero.
    item_o.raw_sum = ipv4e_pkg::SUM_W'({ipv4e_pkg::VER_IHL, 8'h00}) +
                     ipv4e_pkg::SUM_W'(total_len) +
                     ipv4e_pkg::SUM_W'(ipv4e_pkg::FLAGS_DF) +
                     ipv4e_pkg::SUM_W'({ipv4e_pkg::TTL_DEFAULT, item_q.protocol_number}) +
                     ipv4e_pkg::SUM_W'(own_address_i[31:16]) +
                     ipv4e_pkg::SUM_W'(own_address_i[15:0]) +
                     ipv4e_pkg::SUM_W'(item_q.dest_address[31:16]) +
                     ipv4e_pkg::SUM_W'(item_q.dest_address[15:0]);
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/ipv4e_hdr_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_header_encapsulator_assert.svh"

module ipv4e_hdr_seq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  ipv4e_pkg::cls_item_t item_i,
  output logic                 take_o,
  input  wire  [31:0]          own_address_i,
  input  wire  [47:0]          gateway_mac_i,
  input  wire                  res_free_i,
  output logic                 res_valid_o,
  output ipv4e_pkg::res_t      res_o
);

  logic                        b_valid_q;
  ipv4e_pkg::cls_item_t        b_item_q;
  logic [ipv4e_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                        fwd_q, fwd_d;
  logic                        drop_q, drop_d;
  logic [47:0]                 hop_q, hop_d;
  logic                        retire;
  logic [15:0]                 csum;
  logic                        hold_item;
  logic                        hdr_owner;

  assign take_o = !b_valid_q || retire;
  assign csum   = ipv4e_pkg::checksum(b_item_q.raw_sum);

  // Item register between the checks and the byte sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (take_o) begin
      b_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      b_item_q <= item_i;
    end
  end

  // Packet state and header byte counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fwd_q  <= 1'b0;
      drop_q <= 1'b0;
      hop_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      fwd_q  <= fwd_d;
      drop_q <= drop_d;
      hop_q  <= hop_d;
    end
  end

  // Decide what the held item produces this cycle and when it retires.
  always_comb begin
    cnt_d       = cnt_q;
    fwd_d       = fwd_q;
    drop_d      = drop_q;
    hop_d       = hop_q;
    retire      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (b_valid_q) begin
      if (b_item_q.first_byte) begin
        if (b_item_q.status != ipv4e_pkg::ST_OK) begin
          // Error report, then discard the rest of the packet.
          res_valid_o    = 1'b1;
          res_o.out_last = 1'b1;
          res_o.status   = b_item_q.status;
          if (res_free_i) begin
            retire = 1'b1;
            fwd_d  = 1'b0;
            drop_d = !b_item_q.last_byte;
          end
        end else if (cnt_q != ipv4e_pkg::HDR_BYTES) begin
          // Header burst.
          res_valid_o        = 1'b1;
          res_o.is_header    = 1'b1;
          res_o.next_hop_mac = gateway_mac_i;
          res_o.out_byte     = ipv4e_pkg::hdr_byte(cnt_q, b_item_q.total_length,
                                                   b_item_q.protocol_number, own_address_i,
                                                   b_item_q.dest_address, csum);
          if (res_free_i) begin
            cnt_d = cnt_q + ipv4e_pkg::CNT_W'(1);
          end
        end else begin
          // First payload byte closes the burst and opens the packet.
          res_valid_o        = 1'b1;
          res_o.out_byte     = b_item_q.payload_byte;
          res_o.out_last     = b_item_q.last_byte;
          res_o.next_hop_mac = gateway_mac_i;
          if (res_free_i) begin
            retire = 1'b1;
            cnt_d  = '0;
            fwd_d  = !b_item_q.last_byte;
            drop_d = 1'b0;
            hop_d  = gateway_mac_i;
          end
        end
      end else if (fwd_q) begin
        // Payload byte of an open packet.
        res_valid_o        = 1'b1;
        res_o.out_byte     = b_item_q.payload_byte;
        res_o.out_last     = b_item_q.last_byte;
        res_o.next_hop_mac = hop_q;
        if (res_free_i) begin
          retire = 1'b1;
          if (b_item_q.last_byte) begin
            fwd_d = 1'b0;
          end
        end
      end else begin
        // Stray or discarded byte: no result.
        retire = 1'b1;
        if (b_item_q.last_byte) begin
          drop_d = 1'b0;
        end
      end
    end
  end

  // Terms used by the checks below.
  assign hold_item = b_valid_q && !retire;
  assign hdr_owner = b_valid_q && b_item_q.first_byte && (b_item_q.status == ipv4e_pkg::ST_OK);

  `IPV4E_ASSERT_ALWAYS(a_cnt_range, !rst_ni || (cnt_q <= ipv4e_pkg::HDR_BYTES), "counter overflow")
  `IPV4E_ASSERT_ALWAYS(a_fwd_drop_excl, !rst_ni || !(fwd_q && drop_q), "forwarding while dropping")
  `IPV4E_ASSERT(a_cnt_owner, (cnt_q != '0) |-> hdr_owner, "header counter runs without a first byte")
  `IPV4E_ASSERT(a_hdr_hold, hold_item |=> ($stable(b_item_q) && b_valid_q), "held item changed")

endmodule

`default_nettype wire

FILE: rtl/core/ipv4e_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4e_out_reg (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              res_valid_i,
  input  ipv4e_pkg::res_t  res_i,
  output logic             res_free_o,
  output logic             valid_o,
  input  wire              ready_i,
  output ipv4e_pkg::res_t  res_o
);

  logic            valid_q;
  ipv4e_pkg::res_t res_q;

  // Free when empty or when the held result transfers this cycle.
  assign res_free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/ipv4_header_encapsulator.sv
// Path: the first result of an item passes through the input, item and output registers
// in that order before it transfers out.
// Throughput: one payload byte per cycle when the output is not stalled; a first byte holds
// the byte sequencer while 20 header bytes and then itself go out, and the input waits meanwhile.
// Reset (rst_ni low, asynchronous): empties all stages, clears the packet state, the
// latched next-hop MAC and the three configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_encapsulator (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write channel.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [47:0] cfg_data_i,
  // Payload input.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] payload_byte, [23:8] payload_length, [31:24] protocol_number,
  // [63:32] dest_address
  input  wire  [63:0] s_axis_tdata,
  input  wire         s_axis_tlast,  // last_byte
  input  wire         s_axis_tuser,  // [0] first_byte
  // Packet output.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] out_byte, [55:8] next_hop_mac
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,  // out_last
  output logic [2:0]  m_axis_tuser   // [0] is_header, [2:1] status
);

  logic [31:0]          own_q;
  logic [31:0]          mask_q;
  logic [47:0]          gw_q;
  ipv4e_pkg::in_item_t  s_item;
  ipv4e_pkg::cls_item_t cls_item;
  logic                 cls_valid;
  logic                 take;
  logic                 res_valid;
  logic                 res_free;
  ipv4e_pkg::res_t      res;
  ipv4e_pkg::res_t      m_res;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q  <= '0;
      mask_q <= '0;
      gw_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ipv4e_pkg::CFG_OWN_ADDRESS: own_q  <= cfg_data_i[31:0];
        ipv4e_pkg::CFG_SUBNET_MASK: mask_q <= cfg_data_i[31:0];
        ipv4e_pkg::CFG_GATEWAY_MAC: gw_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  always_comb begin
    s_item.payload_byte    = s_axis_tdata[7:0];
    s_item.payload_length  = s_axis_tdata[23:8];
    s_item.protocol_number = s_axis_tdata[31:24];
    s_item.dest_address    = s_axis_tdata[63:32];
    s_item.first_byte      = s_axis_tuser;
    s_item.last_byte       = s_axis_tlast;
  end

  ipv4e_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_item_i      (s_item),
    .own_address_i (own_q),
    .subnet_mask_i (mask_q),
    .take_i        (take),
    .valid_o       (cls_valid),
    .item_o        (cls_item)
  );

  ipv4e_hdr_seq u_hdr_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (cls_valid),
    .item_i        (cls_item),
    .take_o        (take),
    .own_address_i (own_q),
    .gateway_mac_i (gw_q),
    .res_free_i    (res_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ipv4e_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (m_res)
  );

  // Pack the output transfer.
  assign m_axis_tdata = {m_res.next_hop_mac, m_res.out_byte};
  assign m_axis_tlast = m_res.out_last;
  assign m_axis_tuser = {m_res.status, m_res.is_header};

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Register index with no register behind it; a write there must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SEG_ITEMS = 50;
  localparam int unsigned NUM_SEGS = 6;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  ipv4_header_encapsulator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Payload bytes waiting to be sent and packet bytes the block still owes us.
  ipv4e_pkg::in_item_t payload_q[$];
  ipv4e_pkg::res_t     pkt_bytes_due[$];
  ipv4e_pkg::in_item_t on_wire;
  ipv4e_pkg::res_t     want;

  // Local copy of the registers and of the packet state.
  logic [31:0] cfg_own = '0;
  logic [31:0] cfg_mask = '0;
  logic [47:0] cfg_gw = '0;
  logic        pkt_open = 1'b0;
  logic        discarding = 1'b0;
  logic [47:0] latched_mac = '0;

  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 74;
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("ipv4_header_encapsulator test failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  function automatic ipv4e_pkg::res_t make_result(logic [7:0] b, logic last, logic hdr,
                                                  logic [47:0] mac, ipv4e_pkg::status_e st);
    ipv4e_pkg::res_t r;
    r.out_byte = b;
    r.out_last = last;
    r.is_header = hdr;
    r.next_hop_mac = mac;
    r.status = st;
    return r;
  endfunction

  // Works out the packet bytes caused by one accepted payload byte.
  task automatic encapsulate_byte(ipv4e_pkg::in_item_t it);
    logic [15:0] words[10];
    logic [31:0] acc;
    if (!it.first_byte) begin
      if (pkt_open) begin
        pkt_bytes_due.push_back(make_result(it.payload_byte, it.last_byte, 1'b0, latched_mac,
                                            ipv4e_pkg::ST_OK));
        if (it.last_byte) pkt_open = 1'b0;
      end else if (discarding && it.last_byte) begin
        discarding = 1'b0;
      end
      return;
    end
    pkt_open = 1'b0;
    discarding = 1'b0;
    // A bad length wins over a local destination.
    if (it.payload_length == 16'd0 || it.payload_length > ipv4e_pkg::MAX_PAYLOAD) begin
      pkt_bytes_due.push_back(make_result(8'h00, 1'b1, 1'b0, 48'h0, ipv4e_pkg::ST_BAD_LEN));
      discarding = !it.last_byte;
      return;
    end
    if ((it.dest_address & cfg_mask) == (cfg_own & cfg_mask)) begin
      pkt_bytes_due.push_back(make_result(8'h00, 1'b1, 1'b0, 48'h0, ipv4e_pkg::ST_LOCAL));
      discarding = !it.last_byte;
      return;
    end
    latched_mac = cfg_gw;
    words[0] = 16'h4500;
    words[1] = it.payload_length + 16'd20;
    words[2] = 16'h0000;
    words[3] = 16'h4000;
    words[4] = {8'd64, it.protocol_number};
    words[5] = 16'h0000;
    words[6] = cfg_own[31:16];
    words[7] = cfg_own[15:0];
    words[8] = it.dest_address[31:16];
    words[9] = it.dest_address[15:0];
    // Ones' complement sum: add everything, then fold the carries back in twice.
    acc = '0;
    for (int i = 0; i < 10; i++) acc += {16'h0, words[i]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    words[5] = ~acc[15:0];
    for (int i = 0; i < 10; i++) begin
      pkt_bytes_due.push_back(make_result(words[i][15:8], 1'b0, 1'b1, latched_mac,
                                          ipv4e_pkg::ST_OK));
      pkt_bytes_due.push_back(make_result(words[i][7:0], 1'b0, 1'b1, latched_mac,
                                          ipv4e_pkg::ST_OK));
    end
    pkt_bytes_due.push_back(make_result(it.payload_byte, it.last_byte, 1'b0, latched_mac,
                                        ipv4e_pkg::ST_OK));
    pkt_open = !it.last_byte;
  endtask

  // Payload driver: presents the next byte once the current transfer is done.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) encapsulate_byte(on_wire);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (payload_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = payload_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {on_wire.dest_address, on_wire.protocol_number,
                           on_wire.payload_length, on_wire.payload_byte};
          s_axis_tlast <= on_wire.last_byte;
          s_axis_tuser <= on_wire.first_byte;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Packet monitor: checks every output transfer against the oldest due byte.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pkt_bytes_due.size() == 0) begin
          report_mismatch("unexpected output transfer", 64'(m_axis_tdata), 64'h0);
        end else begin
          want = pkt_bytes_due.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", 64'(m_axis_tdata[7:0]), 64'(want.out_byte));
          if (m_axis_tlast !== want.out_last)
            report_mismatch("out_last", 64'(m_axis_tlast), 64'(want.out_last));
          if (m_axis_tuser[0] !== want.is_header)
            report_mismatch("is_header", 64'(m_axis_tuser[0]), 64'(want.is_header));
          if (m_axis_tdata[55:8] !== want.next_hop_mac)
            report_mismatch("next_hop_mac", 64'(m_axis_tdata[55:8]), 64'(want.next_hop_mac));
          if (m_axis_tuser[2:1] !== want.status)
            report_mismatch("status", 64'(m_axis_tuser[2:1]), 64'(want.status));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write over the configuration channel.
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ipv4e_pkg::CFG_OWN_ADDRESS: cfg_own = val[31:0];
      ipv4e_pkg::CFG_SUBNET_MASK: cfg_mask = val[31:0];
      ipv4e_pkg::CFG_GATEWAY_MAC: cfg_gw = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [31:0] own, logic [31:0] mask, logic [47:0] gw);
    write_reg(ipv4e_pkg::CFG_OWN_ADDRESS, {16'($urandom), own});
    write_reg(ipv4e_pkg::CFG_SUBNET_MASK, {16'($urandom), mask});
    write_reg(ipv4e_pkg::CFG_GATEWAY_MAC, gw);
    @(negedge clk_i);
  endtask

  // Waits until every byte is sent and every packet byte has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (payload_q.size() != 0 || s_axis_tvalid || pkt_bytes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Queues n payload bytes; head marks the first byte, close sets last on the final one.
  task automatic push_packet(int n, bit head, bit close, logic [15:0] len, logic [7:0] proto,
                             logic [31:0] dst);
    ipv4e_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.payload_byte = 8'($urandom);
      it.first_byte = head && (i == 0);
      it.last_byte = close && (i == n - 1);
      it.payload_length = it.first_byte ? len : 16'($urandom);
      it.protocol_number = it.first_byte ? proto : 8'($urandom);
      it.dest_address = it.first_byte ? dst : $urandom;
      payload_q.push_back(it);
    end
    if (head) queued_items += n;
  endtask

  function automatic logic [31:0] off_subnet_dest();
    logic [31:0] d;
    d = $urandom;
    if (cfg_mask != '0) begin
      while ((d & cfg_mask) == (cfg_own & cfg_mask)) d = $urandom;
    end
    return d;
  endfunction

  function automatic logic [31:0] local_dest();
    logic [31:0] r;
    r = $urandom;
    return (cfg_own & cfg_mask) | (r & ~cfg_mask);
  endfunction

  // Mostly well-formed packets, plus bad lengths, local destinations and broken framing.
  task automatic add_random_packet();
    int pick;
    int n;
    pick = $urandom_range(99);
    n = $urandom_range(1, 6);
    if (pick < 70)
      push_packet(n, 1, 1, 16'(n), 8'($urandom), off_subnet_dest());
    else if (pick < 78)
      push_packet(n, 1, 1, 16'($urandom_range(1, 65515)), 8'($urandom), off_subnet_dest());
    else if (pick < 84)
      push_packet(n, 1, 1, $urandom_range(1) ? 16'd0 : 16'($urandom_range(65516, 65535)),
                  8'($urandom), $urandom);
    else if (pick < 90)
      push_packet(n, 1, 1, 16'(n), 8'($urandom), local_dest());
    else if (pick < 94)
      push_packet($urandom_range(1, 3), 0, 1'($urandom_range(1)), 16'd0, 8'd0, 32'd0);
    else
      push_packet($urandom_range(1, 3), 1, 0, 16'(n), 8'($urandom), off_subnet_dest());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    program_regs(32'h0A00_0001, 32'hFFFF_FF00, 48'h0123_4567_89AB);

    // Directed part: field extremes, error paths and framing corner cases.
    push_packet(1, 1, 1, 16'd1, 8'h00, 32'hFFFF_FFFF);
    push_packet(3, 1, 1, 16'd3, 8'hFF, 32'h0000_0000);
    push_packet(2, 1, 1, 16'd0, 8'h11, 32'hC0A8_0105);
    push_packet(1, 1, 1, 16'd65516, 8'h06, 32'hC0A8_0105);
    push_packet(2, 1, 1, 16'd65535, 8'h06, 32'h0A00_00FE);
    push_packet(3, 1, 1, 16'd4, 8'h11, 32'h0A00_00FE);
    push_packet(1, 1, 1, 16'd1, 8'h01, 32'h0A00_0001);
    push_packet(2, 0, 1, 16'd0, 8'h00, 32'h0);
    push_packet(2, 1, 1, 16'd65515, 8'h2F, 32'h5A5A_A5A5);
    push_packet(2, 1, 0, 16'd2, 8'h06, 32'hA5A5_5A5A);
    push_packet(2, 1, 1, 16'd2, 8'h11, 32'h0808_0808);
    // Leave this packet open across the next register change.
    push_packet(1, 1, 0, 16'd5, 8'h06, 32'hC0A8_0001);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_drained();
      send_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 74 : 0;
      recv_idle_pct = (seg < 2) ? 74 : (seg < 4) ? 13 : 0;
      case (seg)
        0: program_regs($urandom, 32'hFFFF_FF00, {16'($urandom), 32'($urandom)});
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        2: program_regs(32'h0, 32'h0, 48'h0);
        3: begin
          write_reg(CFG_UNUSED, {16'($urandom), 32'($urandom)});
          program_regs($urandom, 32'hFFFF_0000, {16'($urandom), 32'($urandom)});
        end
        4: program_regs($urandom, 32'hFF00_0000, {16'($urandom), 32'($urandom)});
        default: program_regs($urandom, ~(32'hFFFF_FFFF >> $urandom_range(1, 31)),
                              {16'($urandom), 32'($urandom)});
      endcase
      // The open packet keeps the next hop it was accepted with.
      if (seg == 0) push_packet(2, 0, 1, 16'd0, 8'd0, 32'd0);
      queued_items = 0;
      while (queued_items < SEG_ITEMS) add_random_packet();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("ipv4_header_encapsulator test passed");
    end else begin
      $display("ipv4_header_encapsulator test failed");
    end
    $finish;
  end

endmodule
